// ===== design/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types for the sorted list merge block: request actions and the
// sequencer states.
// ----------------------------------------------------------------------------
package slm_pkg;

	// Action carried by a request
	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_MERGE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_READ,
		ST_READ_EMPTY
	} state_t;

endpackage

// ===== design/slm_cmd_if.sv =====
// ----------------------------------------------------------------------------
// slm_cmd_if
// Request channel of the sorted list merge block: action and load value.
// ----------------------------------------------------------------------------
interface slm_cmd_if;
	logic             valid;
	logic             ready;
	slm_pkg::action_t action;
	logic [15:0]      value;

	modport source (output valid, action, value, input ready);
	modport sink   (input valid, action, value, output ready);
endinterface

// ===== design/slm_res_if.sv =====
// ----------------------------------------------------------------------------
// slm_res_if
// Result channel of the sorted list merge block: one accumulator element
// per result with its flags.
// ----------------------------------------------------------------------------
interface slm_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] element;
	logic        last;
	logic        empty_res;
	logic        overflow;

	modport source (output valid, element, last, empty_res, overflow, input ready);
	modport sink   (input valid, element, last, empty_res, overflow, output ready);
endinterface

// ===== design/sorted_list_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_list_merge
// Keeps an incoming list and an accumulator list of 16-bit values in two
// single-port-write memories and merges the first into the second in place.
// ----------------------------------------------------------------------------
// A load request appends its value to the incoming list; a full list drops
// the value and sets the sticky overflow flag. A clear request empties both
// lists and drops the flag. A merge request first fetches both tails and then
// places one element at a time, walking from the back of the accumulator,
// and it stops as soon as the incoming list is used up, since the remaining
// accumulator entries are then already in place. The single write port of the
// accumulator memory sets that pace. A merge that would not fit leaves both
// lists alone and sets the overflow flag. A read request streams the
// accumulator out in ascending order, one result per cycle while the sink
// keeps ready high; an empty accumulator gives a single result with
// empty_res and last set. New requests are taken only between these
// operations, but a finished result may still sit in the output register
// while the next request is taken. Both memories start undefined; only
// entries below the counts are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_merge #(
	parameter int IN_DEPTH  = 32,
	parameter int ACC_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	slm_cmd_if.sink         cmd,
	slm_res_if.source       res
);

	localparam int IN_AW  = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
	localparam int ACC_AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int IN_CW  = $clog2(IN_DEPTH + 1);
	localparam int ACC_CW = $clog2(ACC_DEPTH + 1);
	localparam int SUM_W  = ((IN_CW > ACC_CW) ? IN_CW : ACC_CW) + 1;

	// Sequencer and list bookkeeping
	slm_pkg::state_t     state_q, state_d;
	logic [IN_CW-1:0]    in_cnt_q;
	logic [ACC_CW-1:0]   acc_cnt_q;
	logic                ovf_q;

	// Merge walk: elements left in each list and the next free slot
	logic [IN_CW-1:0]    a_rem_q;
	logic [ACC_CW-1:0]   b_rem_q;
	logic [ACC_AW-1:0]   dst_q;

	// Read-out walk: next index to fetch, and the fetched element stage
	logic [ACC_CW-1:0]   rd_k_q;
	logic                s1_valid;
	logic                s1_last;

	// Output register
	logic                res_valid_q;
	logic [15:0]         res_element_q;
	logic                res_last_q;
	logic                res_empty_q;
	logic                res_ovf_q;

	// Memories and their ports
	logic [15:0]         in_mem  [IN_DEPTH];
	logic [15:0]         acc_mem [ACC_DEPTH];
	logic                in_we, in_re, acc_we, acc_re;
	logic [IN_AW-1:0]    in_waddr, in_raddr;
	logic [ACC_AW-1:0]   acc_waddr, acc_raddr;
	logic [15:0]         acc_wdata;
	logic [15:0]         in_rdata_q, acc_rdata_q;

	// Decoded control
	logic                accept;
	logic                is_load, is_merge, is_read, is_clear;
	logic                in_full;
	logic [SUM_W-1:0]    merge_sum;
	logic                merge_fits;
	logic                merge_go;
	logic                take_in;
	logic                mrg_active;
	logic                mrg_done;
	logic                out_free;
	logic                move;
	logic                issue;
	logic                rd_end;
	logic                empty_load;

	// ------------------------------------------------------------------------
	// Request decode and walk conditions
	// ------------------------------------------------------------------------
	assign accept   = cmd.valid && cmd.ready;
	assign is_load  = (cmd.action == slm_pkg::ACT_LOAD);
	assign is_merge = (cmd.action == slm_pkg::ACT_MERGE);
	assign is_read  = (cmd.action == slm_pkg::ACT_READ);
	assign is_clear = (cmd.action == slm_pkg::ACT_CLEAR);

	assign in_full    = (in_cnt_q == IN_CW'(IN_DEPTH));
	assign merge_sum  = SUM_W'(in_cnt_q) + SUM_W'(acc_cnt_q);
	assign merge_fits = (merge_sum <= SUM_W'(ACC_DEPTH));
	// an empty incoming list leaves everything as it is
	assign merge_go   = accept && is_merge && merge_fits && (in_cnt_q != '0);

	// Tail compare: a tie keeps the accumulator's element
	assign mrg_active = (state_q == slm_pkg::ST_MERGE);
	assign take_in    = (b_rem_q == '0) || (in_rdata_q > acc_rdata_q);
	assign mrg_done   = mrg_active && take_in && (a_rem_q == IN_CW'(1));

	// Read-out: fetch into stage 1, then move into the output register
	assign out_free   = !res_valid_q || res.ready;
	assign move       = s1_valid && out_free;
	assign issue      = (state_q == slm_pkg::ST_READ) && (!s1_valid || out_free) &&
	                    (rd_k_q != acc_cnt_q);
	assign rd_end     = (state_q == slm_pkg::ST_READ) && (rd_k_q == acc_cnt_q) && !s1_valid;
	assign empty_load = (state_q == slm_pkg::ST_READ_EMPTY) && out_free;

	// ------------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			slm_pkg::ST_IDLE: begin
				if (merge_go) begin
					state_d = slm_pkg::ST_MERGE;
				end else if (accept && is_read) begin
					state_d = (acc_cnt_q == '0) ? slm_pkg::ST_READ_EMPTY : slm_pkg::ST_READ;
				end
			end
			slm_pkg::ST_MERGE: begin
				if (mrg_done) begin
					state_d = slm_pkg::ST_IDLE;
				end
			end
			slm_pkg::ST_READ: begin
				if (rd_end) begin
					state_d = slm_pkg::ST_IDLE;
				end
			end
			slm_pkg::ST_READ_EMPTY: begin
				if (out_free) begin
					state_d = slm_pkg::ST_IDLE;
				end
			end
			default: state_d = slm_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// Outputs of the sequencer: handshake and memory ports
	// ------------------------------------------------------------------------
	always_comb begin
		cmd.ready = (state_q == slm_pkg::ST_IDLE);

		// append a loaded value unless the list is full
		in_we    = accept && is_load && !in_full;
		in_waddr = in_cnt_q[IN_AW-1:0];

		// fetch the incoming tail at the start, then step back on each take
		in_re    = 1'b0;
		in_raddr = '0;
		if (merge_go) begin
			in_re    = 1'b1;
			in_raddr = IN_AW'(in_cnt_q - IN_CW'(1));
		end else if (mrg_active && take_in && (a_rem_q > IN_CW'(1))) begin
			in_re    = 1'b1;
			in_raddr = IN_AW'(a_rem_q - IN_CW'(2));
		end

		// the accumulator read port serves both the merge and the read-out
		acc_re    = 1'b0;
		acc_raddr = '0;
		if (merge_go) begin
			acc_re    = 1'b1;
			acc_raddr = ACC_AW'(acc_cnt_q - ACC_CW'(1));
		end else if (mrg_active && !take_in && (b_rem_q > ACC_CW'(1))) begin
			acc_re    = 1'b1;
			acc_raddr = ACC_AW'(b_rem_q - ACC_CW'(2));
		end else if (issue) begin
			acc_re    = 1'b1;
			acc_raddr = rd_k_q[ACC_AW-1:0];
		end

		// place the larger tail at the highest free slot; it never hits
		// the entry being fetched, which lies below it
		acc_we    = mrg_active;
		acc_waddr = dst_q;
		acc_wdata = take_in ? in_rdata_q : acc_rdata_q;

		res.valid     = res_valid_q;
		res.element   = res_element_q;
		res.last      = res_last_q;
		res.empty_res = res_empty_q;
		res.overflow  = res_ovf_q;
	end

	// ------------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slm_pkg::ST_IDLE;
			in_cnt_q    <= '0;
			acc_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			a_rem_q     <= '0;
			b_rem_q     <= '0;
			dst_q       <= '0;
			rd_k_q      <= '0;
			s1_valid    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (accept) begin
				if (is_load) begin
					if (in_full) begin
						ovf_q <= 1'b1;
					end else begin
						in_cnt_q <= in_cnt_q + IN_CW'(1);
					end
				end
				if (is_merge && !merge_fits) begin
					ovf_q <= 1'b1;
				end
				if (is_read) begin
					rd_k_q <= '0;
				end
				if (is_clear) begin
					in_cnt_q  <= '0;
					acc_cnt_q <= '0;
					ovf_q     <= 1'b0;
				end
			end

			if (merge_go) begin
				a_rem_q <= in_cnt_q;
				b_rem_q <= acc_cnt_q;
				dst_q   <= ACC_AW'(merge_sum - SUM_W'(1));
			end else if (mrg_active) begin
				if (take_in) begin
					a_rem_q <= a_rem_q - IN_CW'(1);
				end else begin
					b_rem_q <= b_rem_q - ACC_CW'(1);
				end
				dst_q <= dst_q - ACC_AW'(1);
			end

			// commit the merge: incoming list empties into the accumulator
			if (mrg_done) begin
				acc_cnt_q <= acc_cnt_q + ACC_CW'(in_cnt_q);
				in_cnt_q  <= '0;
			end

			if (issue) begin
				rd_k_q <= rd_k_q + ACC_CW'(1);
			end

			if (issue) begin
				s1_valid <= 1'b1;
			end else if (move) begin
				s1_valid <= 1'b0;
			end

			if (move || empty_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (issue) begin
			s1_last <= ((rd_k_q + ACC_CW'(1)) == acc_cnt_q);
		end
		if (move) begin
			res_element_q <= acc_rdata_q;
			res_last_q    <= s1_last;
			res_empty_q   <= 1'b0;
			res_ovf_q     <= ovf_q;
		end else if (empty_load) begin
			res_element_q <= '0;
			res_last_q    <= 1'b1;
			res_empty_q   <= 1'b1;
			res_ovf_q     <= ovf_q;
		end
	end

	// ------------------------------------------------------------------------
	// Memories: one write and one registered read per cycle; read data holds
	// while no read is enabled, so it serves as the current tail
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_we) begin
			in_mem[in_waddr] <= cmd.value;
		end
		if (in_re) begin
			in_rdata_q <= in_mem[in_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		if (acc_re) begin
			acc_rdata_q <= acc_mem[acc_raddr];
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_merge_has_incoming: assert property (@(posedge clk) disable iff (!arst_n)
		mrg_active |-> (a_rem_q != '0))
		else $error("merge running with no incoming element left");

	a_stage_only_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> (state_q == slm_pkg::ST_READ))
		else $error("fetched element outside read-out");

	a_acc_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cnt_q <= ACC_CW'(ACC_DEPTH))
		else $error("accumulator count beyond depth");

	a_in_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_cnt_q <= IN_CW'(IN_DEPTH))
		else $error("incoming count beyond depth");

	a_merge_commit: assert property (@(posedge clk) disable iff (!arst_n)
		mrg_done |=> (in_cnt_q == '0) && (state_q == slm_pkg::ST_IDLE))
		else $error("merge finished without emptying the incoming list");

endmodule
